FILE: src/bcint_pkg.sv
package bcint_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   localparam int KIND_W = 1;
   localparam int INDEX_W = 4;
   localparam int VOLT_W = 12;
   localparam int CHG_W = 7;
   localparam int SEG_W = 4;
   localparam int CFG_W = 5;

   localparam int ENTRY_W = VOLT_W + CHG_W;
   localparam int PROD_W = VOLT_W + CHG_W + 2;
   localparam int NUM_W = PROD_W - 1;
   localparam int DEN_W = VOLT_W;
   localparam int RES_W = NUM_W + 2;

   localparam logic [CFG_W-1:0] ENTRIES_RESET = CFG_W'(16);
   localparam int PCT_FULL = 100;
   localparam int PCT_EMPTY = 0;

   localparam logic [KIND_W-1:0] KIND_LOAD = 1'b0;
   localparam logic [KIND_W-1:0] KIND_QUERY = 1'b1;

   typedef struct packed {
      logic go;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } div_req_type;

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_FIRST = 9'b000000010,
      S_LAST  = 9'b000000100,
      S_UP    = 9'b000001000,
      S_DN    = 9'b000010000,
      S_HI    = 9'b000100000,
      S_MUL   = 9'b001000000,
      S_DIVGO = 9'b010000000,
      S_DIV   = 9'b100000000
   } state_type;

endpackage

FILE: src/bcint_ram.sv
module bcint_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/bcint_div.sv
module bcint_div (
   input  logic                      clock,
   input  logic                      reset,
   input  bcint_pkg::div_req_type    req,
   output logic                      done,
   output logic [bcint_pkg::NUM_W-1:0] quot
);
   import bcint_pkg::*;

   localparam int STEP_W = $clog2(NUM_W + 1);

   logic              active_ff, active_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [DEN_W:0]    rem_sh;

   always_comb begin
      active_in = active_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      rem_sh = {rem_ff, quo_ff[NUM_W-1]};
      if (req.go) begin
         active_in = 1'b1;
         step_in = STEP_W'(NUM_W);
         rem_in = '0;
         quo_in = req.num;
         den_in = req.den;
      end else if (active_ff) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = DEN_W'(rem_sh - {1'b0, den_ff});
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            active_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         active_ff <= active_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

FILE: src/battery_charge_interpolator_core.sv
// Voltage-to-charge lookup by piecewise linear interpolation over a table of up to sixteen
// pairs held in one single-port-read RAM. A load beat writes one pair in its own cycle and
// leaves busy low. A query beat keeps busy high while it reads the first entry and, if the
// voltage is above it, the last used entry; if the voltage is also below that one, it walks
// from the stored segment hint to the bracketing segment one RAM read per step and, unless
// the bracketing entries have equal voltages, runs a bit-serial divider of twenty steps.
// Busy falls after the first read when the voltage is at or below the first entry, and
// after the second read when it is at or above the last used entry.
// The result appears on rsp_charge and rsp_segment for exactly one cycle with rsp_strobe
// high, starting at the clock edge at which busy falls; the receiver cannot stall it and
// must take it in that cycle.
module battery_charge_interpolator_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [bcint_pkg::KIND_W-1:0]  req_kind,
   input  logic [bcint_pkg::INDEX_W-1:0] req_entry_index,
   input  logic [bcint_pkg::VOLT_W-1:0]  req_entry_voltage,
   input  logic [bcint_pkg::CHG_W-1:0]   req_entry_charge,
   input  logic [bcint_pkg::VOLT_W-1:0]  req_voltage,
   output logic                          rsp_strobe,
   output logic [bcint_pkg::CHG_W-1:0]   rsp_charge,
   output logic [bcint_pkg::SEG_W-1:0]   rsp_segment,
   input  logic                          csr_we,
   input  logic [bcint_pkg::CFG_W-1:0]   csr_wdata
);
   import bcint_pkg::*;

   state_type            state_ff, state_in;
   logic [CFG_W-1:0]     entries_ff;
   logic [VOLT_W-1:0]    v_ff, v_in;
   logic [CNT_W-1:0]     n_ff, n_in;
   logic [ADDR_W-1:0]    i_ff, i_in;
   logic [ADDR_W-1:0]    hint_ff, hint_in;
   logic [VOLT_W-1:0]    lo_v_ff, lo_v_in, hi_v_ff, hi_v_in;
   logic [CHG_W-1:0]     lo_c_ff, lo_c_in, hi_c_ff, hi_c_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic                 neg_ff, neg_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   logic [CHG_W-1:0]     rsp_charge_ff, rsp_charge_in;
   logic [SEG_W-1:0]     rsp_segment_ff, rsp_segment_in;

   logic                 accept;
   logic                 ram_we;
   logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
   logic [ENTRY_W-1:0]   ram_rdata;
   logic [VOLT_W-1:0]    rd_v;
   logic [CHG_W-1:0]     rd_c;
   logic [ADDR_W-1:0]    nm1, nm2;
   logic signed [VOLT_W:0] dv_num, dv_den;
   logic signed [CHG_W:0]  dc;
   logic signed [NUM_W:0]  q_s;
   logic signed [RES_W-1:0] s0_ext;
   div_req_type          div_req;
   logic                 div_done;
   logic [NUM_W-1:0]     div_quot;

   function automatic logic [CHG_W-1:0] sat_charge(input logic signed [RES_W-1:0] r);
      logic [CHG_W-1:0] c;
      if (r < RES_W'(PCT_EMPTY)) begin
         c = CHG_W'(PCT_EMPTY);
      end else if (r > RES_W'(PCT_FULL)) begin
         c = CHG_W'(PCT_FULL);
      end else begin
         c = r[CHG_W-1:0];
      end
      return c;
   endfunction

   assign accept = start && (state_ff == S_IDLE);
   assign busy = (state_ff != S_IDLE);

   assign ram_we = accept && (req_kind == KIND_LOAD) && (int'(req_entry_index) < TABLE_DEPTH);
   assign ram_waddr = ADDR_W'(req_entry_index);

   bcint_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock(clock),
      .wr_en(ram_we),
      .wr_addr(ram_waddr),
      .wr_data({req_entry_voltage, req_entry_charge}),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   bcint_div u_div (
      .clock(clock),
      .reset(reset),
      .req(div_req),
      .done(div_done),
      .quot(div_quot)
   );

   assign rd_v = ram_rdata[ENTRY_W-1:CHG_W];
   assign rd_c = ram_rdata[CHG_W-1:0];
   assign nm1 = ADDR_W'(n_ff - CNT_W'(1));
   assign nm2 = ADDR_W'(n_ff - CNT_W'(2));

   assign dv_num = $signed({1'b0, v_ff}) - $signed({1'b0, lo_v_ff});
   assign dv_den = $signed({1'b0, hi_v_ff}) - $signed({1'b0, lo_v_ff});
   assign dc = $signed({1'b0, hi_c_ff}) - $signed({1'b0, lo_c_ff});
   assign q_s = neg_ff ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
   assign s0_ext = RES_W'($signed({1'b0, lo_c_ff}));

   always_comb begin
      div_req.go = (state_ff == S_DIVGO);
      div_req.num = prod_ff[PROD_W-1] ? NUM_W'(-prod_ff) : NUM_W'(prod_ff);
      div_req.den = den_ff;
   end

   always_comb begin
      state_in = state_ff;
      v_in = v_ff;
      n_in = n_ff;
      i_in = i_ff;
      hint_in = hint_ff;
      lo_v_in = lo_v_ff;
      lo_c_in = lo_c_ff;
      hi_v_in = hi_v_ff;
      hi_c_in = hi_c_ff;
      prod_in = prod_ff;
      den_in = den_ff;
      neg_in = neg_ff;
      ram_raddr = '0;
      rsp_strobe_in = 1'b0;
      rsp_charge_in = rsp_charge_ff;
      rsp_segment_in = rsp_segment_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && (req_kind == KIND_QUERY)) begin
               v_in = req_voltage;
               if (entries_ff < CFG_W'(2)) begin
                  n_in = CNT_W'(2);
               end else if (int'(entries_ff) > TABLE_DEPTH) begin
                  n_in = CNT_W'(TABLE_DEPTH);
               end else begin
                  n_in = CNT_W'(entries_ff);
               end
               state_in = S_FIRST;
            end
         end
         S_FIRST: begin
            if (v_ff <= rd_v) begin
               hint_in = '0;
               rsp_strobe_in = 1'b1;
               rsp_charge_in = CHG_W'(PCT_EMPTY);
               rsp_segment_in = '0;
               state_in = S_IDLE;
            end else begin
               ram_raddr = nm1;
               state_in = S_LAST;
            end
         end
         S_LAST: begin
            if (v_ff >= rd_v) begin
               hint_in = nm2;
               rsp_strobe_in = 1'b1;
               rsp_charge_in = CHG_W'(PCT_FULL);
               rsp_segment_in = SEG_W'(nm2);
               state_in = S_IDLE;
            end else begin
               i_in = (hint_ff > nm2) ? nm2 : hint_ff;
               ram_raddr = ADDR_W'(i_in + ADDR_W'(1));
               state_in = S_UP;
            end
         end
         S_UP: begin
            if ((i_ff < nm2) && (v_ff > rd_v)) begin
               i_in = ADDR_W'(i_ff + ADDR_W'(1));
               ram_raddr = ADDR_W'(i_ff + ADDR_W'(2));
            end else begin
               ram_raddr = i_ff;
               state_in = S_DN;
            end
         end
         S_DN: begin
            if ((i_ff != '0) && (v_ff < rd_v)) begin
               i_in = ADDR_W'(i_ff - ADDR_W'(1));
               ram_raddr = i_in;
            end else begin
               lo_v_in = rd_v;
               lo_c_in = rd_c;
               ram_raddr = ADDR_W'(i_ff + ADDR_W'(1));
               state_in = S_HI;
            end
         end
         S_HI: begin
            hi_v_in = rd_v;
            hi_c_in = rd_c;
            state_in = S_MUL;
         end
         S_MUL: begin
            hint_in = i_ff;
            if (dv_den == '0) begin
               rsp_strobe_in = 1'b1;
               rsp_charge_in = sat_charge(s0_ext);
               rsp_segment_in = SEG_W'(i_ff);
               state_in = S_IDLE;
            end else begin
               prod_in = PROD_W'(dv_num) * PROD_W'(dc);
               den_in = dv_den[VOLT_W] ? DEN_W'(-dv_den) : DEN_W'(dv_den);
               neg_in = dv_den[VOLT_W] ^ (dv_num[VOLT_W] ^ dc[CHG_W]);
               state_in = S_DIVGO;
            end
         end
         S_DIVGO: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               rsp_strobe_in = 1'b1;
               rsp_charge_in = sat_charge(s0_ext + RES_W'(q_s));
               rsp_segment_in = SEG_W'(i_ff);
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         entries_ff <= ENTRIES_RESET;
         hint_ff <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            entries_ff <= csr_wdata;
         end
         hint_ff <= hint_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      v_ff <= v_in;
      n_ff <= n_in;
      i_ff <= i_in;
      lo_v_ff <= lo_v_in;
      lo_c_ff <= lo_c_in;
      hi_v_ff <= hi_v_in;
      hi_c_ff <= hi_c_in;
      prod_ff <= prod_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      rsp_charge_ff <= rsp_charge_in;
      rsp_segment_ff <= rsp_segment_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_charge = rsp_charge_ff;
   assign rsp_segment = rsp_segment_ff;

endmodule

FILE: verif/testbench.sv
module testbench;
   import bcint_pkg::*;

   typedef struct packed {
      logic [CHG_W-1:0] charge;
      logic [SEG_W-1:0] segment;
   } reading_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [KIND_W-1:0] req_kind = KIND_LOAD;
   logic [INDEX_W-1:0] req_entry_index = '0;
   logic [VOLT_W-1:0] req_entry_voltage = '0;
   logic [CHG_W-1:0] req_entry_charge = '0;
   logic [VOLT_W-1:0] req_voltage = '0;
   logic rsp_strobe;
   logic [CHG_W-1:0] rsp_charge;
   logic [SEG_W-1:0] rsp_segment;
   logic csr_we = 1'b0;
   logic [CFG_W-1:0] csr_wdata = '0;

   logic [VOLT_W-1:0] cal_volts [TABLE_DEPTH];
   logic [CHG_W-1:0] cal_pct [TABLE_DEPTH];
   logic [CFG_W-1:0] pairs_used = ENTRIES_RESET;
   int walk_start = 0;
   reading_type pending_readings[$];
   int mismatches = 0;
   int sender_idle_pct = 0;

   battery_charge_interpolator_core DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_kind(req_kind),
      .req_entry_index(req_entry_index),
      .req_entry_voltage(req_entry_voltage),
      .req_entry_charge(req_entry_charge),
      .req_voltage(req_voltage),
      .rsp_strobe(rsp_strobe),
      .rsp_charge(rsp_charge),
      .rsp_segment(rsp_segment),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic int effective_pairs();
      int n;
      n = pairs_used;
      if (n < 2) n = 2;
      if (n > TABLE_DEPTH) n = TABLE_DEPTH;
      return n;
   endfunction

   function automatic reading_type predict_reading(input logic [VOLT_W-1:0] v);
      int n, i, vi, v0, v1, s0, s1, r;
      reading_type res;
      n = effective_pairs();
      vi = v;
      if (v <= cal_volts[0]) begin
         walk_start = 0;
         r = PCT_EMPTY;
      end else if (v >= cal_volts[n-1]) begin
         walk_start = n - 2;
         r = PCT_FULL;
      end else begin
         i = walk_start;
         if (i > n - 2) i = n - 2;
         while (i < n - 2 && v > cal_volts[i+1]) i++;
         while (i > 0 && v < cal_volts[i]) i--;
         walk_start = i;
         v0 = cal_volts[i];
         v1 = cal_volts[i+1];
         s0 = cal_pct[i];
         s1 = cal_pct[i+1];
         if (v1 == v0) r = s0;
         else r = s0 + ((vi - v0) * (s1 - s0)) / (v1 - v0);
         if (r < PCT_EMPTY) r = PCT_EMPTY;
         if (r > PCT_FULL) r = PCT_FULL;
      end
      res.charge = r[CHG_W-1:0];
      res.segment = walk_start[SEG_W-1:0];
      return res;
   endfunction

   task automatic send_beat(input logic [KIND_W-1:0] kind, input logic [INDEX_W-1:0] idx,
                            input logic [VOLT_W-1:0] ev, input logic [CHG_W-1:0] ec,
                            input logic [VOLT_W-1:0] v);
      int gap;
      gap = 0;
      while (gap < 24 && $urandom_range(0, 99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_kind <= kind;
      req_entry_index <= idx;
      req_entry_voltage <= ev;
      req_entry_charge <= ec;
      req_voltage <= v;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (kind == KIND_LOAD) begin
         cal_volts[idx] = ev;
         cal_pct[idx] = ec;
      end else begin
         pending_readings.push_back(predict_reading(v));
      end
   endtask

   task automatic send_load(input int idx, input int ev, input int ec);
      send_beat(KIND_LOAD, idx[INDEX_W-1:0], ev[VOLT_W-1:0], ec[CHG_W-1:0],
                VOLT_W'($urandom));
   endtask

   task automatic send_query(input int v);
      send_beat(KIND_QUERY, INDEX_W'($urandom), VOLT_W'($urandom), CHG_W'($urandom),
                v[VOLT_W-1:0]);
   endtask

   task automatic wait_for_quiet();
      start <= 1'b0;
      @(posedge clock);
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_pairs_used(input logic [CFG_W-1:0] value);
      wait_for_quiet();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      pairs_used = value;
   endtask

   task automatic test_two_point_table();
      write_pairs_used(CFG_W'(2));
      send_load(0, 1000, 0);
      send_load(1, 2000, 100);
      send_query(0);
      send_query(1000);
      send_query(1001);
      send_query(1500);
      send_query(1999);
      send_query(2000);
      send_query(4095);
   endtask

   // Covers saturation above 100, equal neighboring voltages and truncation of a
   // negative quotient toward zero.
   task automatic test_interpolation_corners();
      write_pairs_used(CFG_W'(4));
      send_load(0, 100, 10);
      send_load(1, 200, 40);
      send_load(2, 300, 127);
      send_load(3, 400, 0);
      send_query(250);
      send_query(290);
      send_load(2, 200, 5);
      send_query(200);
      send_query(350);
   endtask

   task automatic test_stale_hint_and_walk_limits();
      write_pairs_used(CFG_W'(2));
      send_query(150);
      write_pairs_used(CFG_W'(4));
      send_load(1, 50, 20);
      send_load(2, 60, 30);
      send_query(300);
      send_query(80);
   endtask

   task automatic load_random_table();
      int shape, acc, pct, k, ev, ec;
      shape = $urandom_range(0, 9);
      acc = (shape == 9) ? 0 : $urandom_range(0, 600);
      pct = $urandom_range(0, 10);
      for (k = 0; k < TABLE_DEPTH; k++) begin
         if (shape == 8) begin
            ev = $urandom_range(0, 4095);
            ec = $urandom_range(0, 127);
         end else begin
            ev = (shape == 9 && k == TABLE_DEPTH - 1) ? 4095 : acc;
            ec = pct;
            if (shape == 7 && $urandom_range(0, 3) == 0) acc += 0;
            else acc += $urandom_range(1, 230);
            pct += $urandom_range(0, 12);
            if (pct > ((shape == 6) ? 127 : 100)) pct = (shape == 6) ? 127 : 100;
         end
         send_load(k, ev, ec);
      end
   endtask

   function automatic int pick_voltage();
      int n, lo, hi, sel;
      n = effective_pairs();
      lo = cal_volts[0];
      hi = cal_volts[n-1];
      sel = $urandom_range(0, 99);
      if (sel < 60 && hi > lo + 1) return $urandom_range(lo + 1, hi - 1);
      if (sel < 80) return (cal_volts[$urandom_range(0, n - 1)] + $urandom_range(0, 2) + 4095)
                           % 4096;
      if (sel < 85) return 0;
      if (sel < 90) return 4095;
      return $urandom_range(0, 4095);
   endfunction

   task automatic test_random_tables();
      logic [CFG_W-1:0] cfg_plan [9];
      int phase, k;
      cfg_plan = '{CFG_W'(16), CFG_W'(2), CFG_W'(31), CFG_W'(0), CFG_W'(9), CFG_W'(1),
                   CFG_W'(17), CFG_W'(5), CFG_W'(0)};
      cfg_plan[8] = CFG_W'($urandom_range(0, 31));
      for (phase = 0; phase < 9; phase++) begin
         write_pairs_used(cfg_plan[phase]);
         case (phase % 3)
            0: sender_idle_pct = 0;
            1: sender_idle_pct = 63;
            default: sender_idle_pct = 8;
         endcase
         load_random_table();
         for (k = 0; k < 32; k++) begin
            if ($urandom_range(0, 99) < 10)
               send_load($urandom_range(0, 15), $urandom_range(0, 4095), $urandom_range(0, 127));
            else
               send_query(pick_voltage());
         end
      end
   endtask

   always @(posedge clock) begin : check_results
      reading_type want;
      if (!reset && rsp_strobe) begin
         if (pending_readings.size() == 0) begin
            $display("%0t: unexpected beat, charge %0d segment %0d", $time, rsp_charge,
                     rsp_segment);
            mismatches++;
         end else begin
            want = pending_readings.pop_front();
            if (rsp_charge !== want.charge) begin
               $display("%0t: charge expected %0d actual %0d", $time, want.charge, rsp_charge);
               mismatches++;
            end
            if (rsp_segment !== want.segment) begin
               $display("%0t: segment expected %0d actual %0d", $time, want.segment,
                        rsp_segment);
               mismatches++;
            end
         end
      end
   end

   initial begin
      #2000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_two_point_table();
      test_interpolation_corners();
      test_stale_hint_and_walk_limits();
      test_random_tables();
      wait_for_quiet();
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: sim.f
src/bcint_pkg.sv
src/bcint_ram.sv
src/bcint_div.sv
src/battery_charge_interpolator_core.sv
verif/testbench.sv
